/* sv/eura_pkg.sv */
// Shared types and constants for the encoder unwrap and rate average block.
package eura_pkg;

   // Field widths.
   localparam int ANGLE_W  = 13;
   localparam int WORD_W   = 16;
   localparam int TEMP_W   = 8;
   localparam int POS_W    = 30;
   localparam int SCALED_W = 35;
   localparam int TURN_W   = 16;
   localparam int RATE_W   = 14;

   // Encoder and scaling constants.
   localparam int COUNTS_PER_TURN = 8192;
   localparam int DEG_SCALE       = 45;
   localparam logic [ANGLE_W-1:0] THRESHOLD_RESET = 13'd6000;

   // Turn counter limits.
   localparam logic signed [TURN_W-1:0] TURN_MAX = 16'sh7FFF;
   localparam logic signed [TURN_W-1:0] TURN_MIN = 16'sh8000;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCOUNT_W    = 2;

   // One classified frame as it travels from the front to the back.
   typedef struct packed {
      logic signed [POS_W-1:0]  position;
      logic signed [TURN_W-1:0] turns;
      logic signed [RATE_W-1:0] rate;
      logic [WORD_W-1:0]        speed;
      logic [WORD_W-1:0]        current;
      logic [TEMP_W-1:0]        temperature;
   } frame_type;

   // Queue status seen by both sides.
   typedef struct packed {
      logic                full;
      logic                empty;
      logic [QCOUNT_W-1:0] count;
   } queue_status_type;

endpackage

/* sv/encoder_unwrap_rate_average_core.sv */
// Top level of the multiturn encoder unwrapper with moving-average step rate.
//
// The req_ channel carries one motor feedback transaction: a 13-bit encoder
// angle, speed word, current word and temperature byte. The rsp_ channel
// returns exactly one result transaction for each: unwrapped position counts,
// the angle in 1/1024 degree, the turn count, the step rate, the average rate
// over the last RING_DEPTH frames, and the passthrough fields. Both channels
// use valid and stall; a transaction moves when valid is high and stall low.
// The csr_ port writes the wrap threshold; write it only while the block is idle.
//
// A transaction accepted by the front is written into the queue and then
// taken into the result register. Throughput is one transaction per cycle
// while rsp_stall is low, with the unwrap in the front and the rate update
// in the back joined by a two-entry queue.
// When rsp_stall is high the result holds, the queue fills, and req_stall
// rises once both queue entries are taken. Synchronous reset clears the turn
// count, the start flag, the rate history and running sum, the queue, and sets
// the threshold to 6000; the block accepts transactions in the next cycle.
module encoder_unwrap_rate_average_core #(
   parameter int RING_DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [eura_pkg::ANGLE_W-1:0]          csr_wr_data,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [eura_pkg::ANGLE_W-1:0]          req_encoder_angle,
   input  logic [eura_pkg::WORD_W-1:0]           req_speed_word,
   input  logic [eura_pkg::WORD_W-1:0]           req_current_word,
   input  logic [eura_pkg::TEMP_W-1:0]           req_temperature_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [eura_pkg::POS_W-1:0]     rsp_position_counts,
   output logic signed [eura_pkg::SCALED_W-1:0]  rsp_angle_scaled,
   output logic signed [eura_pkg::TURN_W-1:0]    rsp_turn_count,
   output logic signed [eura_pkg::RATE_W-1:0]    rsp_step_rate,
   output logic signed [eura_pkg::RATE_W-1:0]    rsp_average_rate,
   output logic [eura_pkg::WORD_W-1:0]           rsp_speed_out,
   output logic [eura_pkg::WORD_W-1:0]           rsp_current_out,
   output logic [eura_pkg::TEMP_W-1:0]           rsp_temperature_out
);

   logic                        push;
   logic                        pop;
   logic                        started;
   eura_pkg::frame_type         push_frame;
   eura_pkg::frame_type         head_frame;
   eura_pkg::queue_status_type  queue_status;

   // Front: accept and unwrap.
   eura_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_encoder_angle  (req_encoder_angle),
      .req_speed_word     (req_speed_word),
      .req_current_word   (req_current_word),
      .req_temperature_in (req_temperature_in),
      .queue_status       (queue_status),
      .push               (push),
      .push_frame         (push_frame),
      .started            (started)
   );

   // Queue between the two parts.
   eura_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (push_frame),
      .pop        (pop),
      .head_frame (head_frame),
      .status     (queue_status)
   );

   // Back: averaging, scaling and result register.
   eura_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .head_frame          (head_frame),
      .queue_status        (queue_status),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_position_counts (rsp_position_counts),
      .rsp_angle_scaled    (rsp_angle_scaled),
      .rsp_turn_count      (rsp_turn_count),
      .rsp_step_rate       (rsp_step_rate),
      .rsp_average_rate    (rsp_average_rate),
      .rsp_speed_out       (rsp_speed_out),
      .rsp_current_out     (rsp_current_out),
      .rsp_temperature_out (rsp_temperature_out)
   );

`ifndef ASSERT_OFF
   // The queue never holds more than its depth.
   assert property (@(posedge clock) disable iff (reset)
      queue_status.count <= eura_pkg::QCOUNT_W'(eura_pkg::QUEUE_DEPTH))
      else $error("queue occupancy exceeds its depth");

   // Before the first transaction nothing can be queued or presented.
   assert property (@(posedge clock) disable iff (reset)
      !started |-> (queue_status.empty && !rsp_valid))
      else $error("result or queued transaction before the first frame");

   // A transaction taken from the queue shows up in the result register.
   assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid)
      else $error("popped transaction did not reach the result register");

   // The mean never exceeds the largest possible step rate magnitude.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_average_rate != 14'sh2000))
      else $error("average rate out of range");
`endif

endmodule

/* sv/eura_front.sv */
// Front part: accepts frames, unwraps the angle and tracks the turn count.
module eura_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [eura_pkg::ANGLE_W-1:0]       csr_wr_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [eura_pkg::ANGLE_W-1:0]       req_encoder_angle,
   input  logic [eura_pkg::WORD_W-1:0]        req_speed_word,
   input  logic [eura_pkg::WORD_W-1:0]        req_current_word,
   input  logic [eura_pkg::TEMP_W-1:0]        req_temperature_in,
   input  eura_pkg::queue_status_type         queue_status,
   output logic                               push,
   output eura_pkg::frame_type                push_frame,
   output logic                               started
);

   logic                                 started_ff, started_in;
   logic [eura_pkg::ANGLE_W-1:0]         bias_ff, bias_in;
   logic [eura_pkg::ANGLE_W-1:0]         prev_ff;
   logic signed [eura_pkg::TURN_W-1:0]   turns_ff, turns_in;
   logic [eura_pkg::ANGLE_W-1:0]         threshold_ff;
   logic [eura_pkg::ANGLE_W-1:0]         prev_angle;
   logic signed [eura_pkg::ANGLE_W+1:0]  diff;
   logic signed [eura_pkg::ANGLE_W+1:0]  thr;
   logic signed [eura_pkg::ANGLE_W+1:0]  rate_wide;
   logic signed [eura_pkg::ANGLE_W:0]    offset;
   logic                                 wrap_up;
   logic                                 wrap_down;
   logic                                 accept;

   // A transaction is taken whenever the queue has room.
   assign req_stall = queue_status.full;
   assign accept    = req_valid && !req_stall;
   assign push      = accept;
   assign started   = started_ff;

   // Unwrap the angle step and update the turn count.
   always_comb begin
      started_in = 1'b1;
      bias_in    = started_ff ? bias_ff : req_encoder_angle;
      prev_angle = started_ff ? prev_ff : req_encoder_angle;
      diff       = $signed({2'b00, req_encoder_angle}) - $signed({2'b00, prev_angle});
      thr        = $signed({2'b00, threshold_ff});
      wrap_up    = diff < -thr;
      wrap_down  = diff > thr;
      turns_in   = turns_ff;
      rate_wide  = diff;
      if (wrap_up) begin
         rate_wide = diff + $signed(15'(eura_pkg::COUNTS_PER_TURN));
         if (turns_ff != eura_pkg::TURN_MAX) begin
            turns_in = turns_ff + 16'sd1;
         end
      end else if (wrap_down) begin
         rate_wide = diff - $signed(15'(eura_pkg::COUNTS_PER_TURN));
         if (turns_ff != eura_pkg::TURN_MIN) begin
            turns_in = turns_ff - 16'sd1;
         end
      end
      offset = $signed({1'b0, req_encoder_angle}) - $signed({1'b0, bias_in});

      // Whole turns sit above the 13 angle bits.
      push_frame.position    = $signed({turns_in[eura_pkg::TURN_W-1], turns_in,
                                         13'b0})
                               + $signed({{16{offset[eura_pkg::ANGLE_W]}}, offset});
      push_frame.turns       = turns_in;
      push_frame.rate        = rate_wide[eura_pkg::RATE_W-1:0];
      push_frame.speed       = req_speed_word;
      push_frame.current     = req_current_word;
      push_frame.temperature = req_temperature_in;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         turns_ff     <= '0;
         threshold_ff <= eura_pkg::THRESHOLD_RESET;
      end else begin
         if (accept) begin
            started_ff <= started_in;
            turns_ff   <= turns_in;
         end
         if (csr_wr_en) begin
            threshold_ff <= csr_wr_data;
         end
      end
   end

   // Angle history, only read once the first frame has been seen.
   always_ff @(posedge clock) begin
      if (accept) begin
         bias_ff <= bias_in;
         prev_ff <= req_encoder_angle;
      end
   end

endmodule

/* sv/eura_queue.sv */
// Two-entry queue that decouples the front from the back.
module eura_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  eura_pkg::frame_type         push_frame,
   input  logic                        pop,
   output eura_pkg::frame_type         head_frame,
   output eura_pkg::queue_status_type  status
);

   eura_pkg::frame_type                entries_ff [eura_pkg::QUEUE_DEPTH];
   logic [eura_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [eura_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [eura_pkg::QCOUNT_W-1:0]      count_ff, count_in;

   // Status and head of the queue.
   always_comb begin
      status.count = count_ff;
      status.full  = count_ff == eura_pkg::QCOUNT_W'(eura_pkg::QUEUE_DEPTH);
      status.empty = count_ff == '0;
      head_frame   = entries_ff[rd_ptr_ff];
   end

   // Pointer and count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == eura_pkg::QPTR_W'(eura_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == eura_pkg::QPTR_W'(eura_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_frame;
      end
   end

endmodule

/* sv/eura_back.sv */
// Back part: rate history, running average, angle scaling and result register.
module eura_back #(
   parameter int RING_DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  eura_pkg::frame_type                   head_frame,
   input  eura_pkg::queue_status_type            queue_status,
   output logic                                  pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [eura_pkg::POS_W-1:0]     rsp_position_counts,
   output logic signed [eura_pkg::SCALED_W-1:0]  rsp_angle_scaled,
   output logic signed [eura_pkg::TURN_W-1:0]    rsp_turn_count,
   output logic signed [eura_pkg::RATE_W-1:0]    rsp_step_rate,
   output logic signed [eura_pkg::RATE_W-1:0]    rsp_average_rate,
   output logic [eura_pkg::WORD_W-1:0]           rsp_speed_out,
   output logic [eura_pkg::WORD_W-1:0]           rsp_current_out,
   output logic [eura_pkg::TEMP_W-1:0]           rsp_temperature_out
);

   localparam int DEPTH_LOG = $clog2(RING_DEPTH);
   localparam int TOTAL_W   = eura_pkg::RATE_W + DEPTH_LOG;
   localparam int MAG_W     = TOTAL_W - 1;
   localparam int SHIFT     = MAG_W + DEPTH_LOG;
   localparam int RECIP_W   = MAG_W + 1;
   localparam int PROD_W    = MAG_W + RECIP_W;
   // Rounded-up reciprocal; exact floor for every magnitude below 2**MAG_W.
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << SHIFT) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH));

   logic signed [eura_pkg::RATE_W-1:0]   rate_line_ff [RING_DEPTH];
   logic signed [TOTAL_W-1:0]            total_ff, total_in;
   logic                                 valid_ff;
   logic signed [eura_pkg::POS_W-1:0]    position_ff;
   logic signed [eura_pkg::SCALED_W-1:0] scaled_ff, scaled_in;
   logic signed [eura_pkg::TURN_W-1:0]   turns_ff;
   logic signed [eura_pkg::RATE_W-1:0]   rate_ff;
   logic signed [eura_pkg::RATE_W-1:0]   average_ff, average_in;
   logic [eura_pkg::WORD_W-1:0]          speed_ff;
   logic [eura_pkg::WORD_W-1:0]          current_ff;
   logic [eura_pkg::TEMP_W-1:0]          temperature_ff;
   logic signed [TOTAL_W-1:0]            tail_ext;
   logic signed [TOTAL_W-1:0]            rate_ext;
   logic [TOTAL_W-1:0]                   total_neg;
   logic [MAG_W-1:0]                     magnitude;
   logic [PROD_W-1:0]                    product;
   logic [eura_pkg::RATE_W-1:0]          quotient;
   logic signed [eura_pkg::SCALED_W-1:0] position_ext;

   // Move a transaction out of the queue when the result register is free.
   assign pop = !queue_status.empty && (!valid_ff || !rsp_stall);

   // Running sum over the last RING_DEPTH rates, then its mean toward zero.
   always_comb begin
      tail_ext = {{(TOTAL_W - eura_pkg::RATE_W){rate_line_ff[RING_DEPTH-1][eura_pkg::RATE_W-1]}},
                  rate_line_ff[RING_DEPTH-1]};
      rate_ext = {{(TOTAL_W - eura_pkg::RATE_W){head_frame.rate[eura_pkg::RATE_W-1]}},
                  head_frame.rate};
      total_in  = total_ff - tail_ext + rate_ext;
      total_neg = -total_in;
      magnitude = total_in[TOTAL_W-1] ? total_neg[MAG_W-1:0] : total_in[MAG_W-1:0];
      product   = {{RECIP_W{1'b0}}, magnitude} * {{MAG_W{1'b0}}, RECIP};
      quotient  = product[SHIFT +: eura_pkg::RATE_W];
      average_in = total_in[TOTAL_W-1] ? -$signed(quotient) : $signed(quotient);
   end

   // Angle in 1/1024 degree: counts times 45.
   always_comb begin
      position_ext = {{(eura_pkg::SCALED_W - eura_pkg::POS_W)
                       {head_frame.position[eura_pkg::POS_W-1]}}, head_frame.position};
      scaled_in    = position_ext * $signed(eura_pkg::SCALED_W'(eura_pkg::DEG_SCALE));
   end

   // Rate history and running sum; cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         valid_ff <= 1'b0;
         for (int i = 0; i < RING_DEPTH; i++) begin
            rate_line_ff[i] <= '0;
         end
      end else begin
         if (pop) begin
            total_ff        <= total_in;
            rate_line_ff[0] <= head_frame.rate;
            for (int i = 1; i < RING_DEPTH; i++) begin
               rate_line_ff[i] <= rate_line_ff[i-1];
            end
         end
         if (pop) begin
            valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (pop) begin
         position_ff    <= head_frame.position;
         scaled_ff      <= scaled_in;
         turns_ff       <= head_frame.turns;
         rate_ff        <= head_frame.rate;
         average_ff     <= average_in;
         speed_ff       <= head_frame.speed;
         current_ff     <= head_frame.current;
         temperature_ff <= head_frame.temperature;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_position_counts = position_ff;
   assign rsp_angle_scaled    = scaled_ff;
   assign rsp_turn_count      = turns_ff;
   assign rsp_step_rate       = rate_ff;
   assign rsp_average_rate    = average_ff;
   assign rsp_speed_out       = speed_ff;
   assign rsp_current_out     = current_ff;
   assign rsp_temperature_out = temperature_ff;

endmodule

/* tb/tb_encoder_unwrap_rate_average_core.sv */
// Testbench for the encoder unwrap and rate average core, checked against a local predictor.
`timescale 1ns / 1ps

module tb_encoder_unwrap_rate_average_core;

   localparam int RING_DEPTH  = 8;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int MAX_REPORTS = 30;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   // One expected result transaction.
   typedef struct {
      logic signed [eura_pkg::POS_W-1:0]    position;
      logic signed [eura_pkg::SCALED_W-1:0] scaled;
      logic signed [eura_pkg::TURN_W-1:0]   turns;
      logic signed [eura_pkg::RATE_W-1:0]   rate;
      logic signed [eura_pkg::RATE_W-1:0]   average;
      logic [eura_pkg::WORD_W-1:0]          speed;
      logic [eura_pkg::WORD_W-1:0]          current;
      logic [eura_pkg::TEMP_W-1:0]          temp;
   } feedback_result_type;

   logic                                  clock;
   logic                                  reset = 1'b1;
   logic                                  csr_wr_en = 1'b0;
   logic [eura_pkg::ANGLE_W-1:0]          csr_wr_data = '0;
   logic                                  req_valid = 1'b0;
   logic                                  req_stall;
   logic [eura_pkg::ANGLE_W-1:0]          req_encoder_angle = '0;
   logic [eura_pkg::WORD_W-1:0]           req_speed_word = '0;
   logic [eura_pkg::WORD_W-1:0]           req_current_word = '0;
   logic [eura_pkg::TEMP_W-1:0]           req_temperature_in = '0;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   logic signed [eura_pkg::POS_W-1:0]     rsp_position_counts;
   logic signed [eura_pkg::SCALED_W-1:0]  rsp_angle_scaled;
   logic signed [eura_pkg::TURN_W-1:0]    rsp_turn_count;
   logic signed [eura_pkg::RATE_W-1:0]    rsp_step_rate;
   logic signed [eura_pkg::RATE_W-1:0]    rsp_average_rate;
   logic [eura_pkg::WORD_W-1:0]           rsp_speed_out;
   logic [eura_pkg::WORD_W-1:0]           rsp_current_out;
   logic [eura_pkg::TEMP_W-1:0]           rsp_temperature_out;

   // Predictor state, as it stands after the last accepted transaction.
   bit  enc_started = 1'b0;
   int  enc_bias = 0;
   int  enc_prev = 0;
   int  enc_turns = 0;
   int  rate_hist [RING_DEPTH];
   int  hist_slot = 0;
   int  rate_sum = 0;
   int  wrap_thr = eura_pkg::THRESHOLD_RESET;

   feedback_result_type pending_results [$];
   feedback_result_type want;
   int                  mismatch_count = 0;
   int                  cycle_count = 0;
   int unsigned         send_idle_pct = 0;
   int unsigned         stall_pct = 0;

   encoder_unwrap_rate_average_core #(
      .RING_DEPTH(RING_DEPTH)
   ) u_top (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_encoder_angle   (req_encoder_angle),
      .req_speed_word      (req_speed_word),
      .req_current_word    (req_current_word),
      .req_temperature_in  (req_temperature_in),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_position_counts (rsp_position_counts),
      .rsp_angle_scaled    (rsp_angle_scaled),
      .rsp_turn_count      (rsp_turn_count),
      .rsp_step_rate       (rsp_step_rate),
      .rsp_average_rate    (rsp_average_rate),
      .rsp_speed_out       (rsp_speed_out),
      .rsp_current_out     (rsp_current_out),
      .rsp_temperature_out (rsp_temperature_out)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The run ends here if the results stop coming.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   // Unwraps one frame, advances the turn count and the rate history, and
   // returns the result transaction that the block should give for it.
   function automatic feedback_result_type unwrap_frame(
         input logic [eura_pkg::ANGLE_W-1:0] angle,
         input logic [eura_pkg::WORD_W-1:0] speed, current,
         input logic [eura_pkg::TEMP_W-1:0] temp);
      feedback_result_type r;
      int                  diff;
      int                  rate;
      longint              pos;
      if (!enc_started) begin
         enc_bias    = int'(angle);
         enc_prev    = int'(angle);
         enc_started = 1'b1;
      end
      diff = int'(angle) - enc_prev;
      if (diff < -wrap_thr) begin
         if (enc_turns < eura_pkg::TURN_MAX) enc_turns++;
         rate = diff + eura_pkg::COUNTS_PER_TURN;
      end else if (diff > wrap_thr) begin
         if (enc_turns > eura_pkg::TURN_MIN) enc_turns--;
         rate = diff - eura_pkg::COUNTS_PER_TURN;
      end else begin
         rate = diff;
      end
      enc_prev = int'(angle);
      pos = longint'(enc_turns) * eura_pkg::COUNTS_PER_TURN + longint'(int'(angle))
            - enc_bias;

      // The running sum stands in for a walk over the history.
      rate_sum = rate_sum - rate_hist[hist_slot] + rate;
      rate_hist[hist_slot] = rate;
      hist_slot = (hist_slot + 1) % RING_DEPTH;

      r.position = eura_pkg::POS_W'(pos);
      r.scaled   = eura_pkg::SCALED_W'(pos * eura_pkg::DEG_SCALE);
      r.turns    = eura_pkg::TURN_W'(enc_turns);
      r.rate     = eura_pkg::RATE_W'(rate);
      r.average  = eura_pkg::RATE_W'(rate_sum / RING_DEPTH);
      r.speed    = speed;
      r.current  = current;
      r.temp     = temp;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_REPORTS) $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic signed [63:0] got,
         input logic signed [63:0] expected);
      if (got !== expected)
         report_mismatch($sformatf("%s is %0d, expected %0d", name, got, expected));
   endtask

   // Each accepted result transaction is held against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with no frame waiting");
         end else begin
            want = pending_results.pop_front();
            check_field("position_counts", rsp_position_counts, want.position);
            check_field("angle_scaled", rsp_angle_scaled, want.scaled);
            check_field("turn_count", rsp_turn_count, want.turns);
            check_field("step_rate", rsp_step_rate, want.rate);
            check_field("average_rate", rsp_average_rate, want.average);
            check_field("speed_out", rsp_speed_out, want.speed);
            check_field("current_out", rsp_current_out, want.current);
            check_field("temperature_out", rsp_temperature_out, want.temp);
         end
      end
   end

   // Result side stalls at random, at the rate of the current phase.
   always @(posedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 77;
            stall_pct     = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            stall_pct     = 77;
         end
         default: begin
            send_idle_pct = 15;
            stall_pct     = 15;
         end
      endcase
   endtask

   // Offers one frame transaction and records its expected result once taken.
   task automatic send_frame(input logic [eura_pkg::ANGLE_W-1:0] angle,
         input logic [eura_pkg::WORD_W-1:0] speed, current,
         input logic [eura_pkg::TEMP_W-1:0] temp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_encoder_angle  <= angle;
      req_speed_word     <= speed;
      req_current_word   <= current;
      req_temperature_in <= temp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(unwrap_frame(angle, speed, current, temp));
   endtask

   task automatic send_angle(input logic [eura_pkg::ANGLE_W-1:0] angle);
      send_frame(angle, eura_pkg::WORD_W'($urandom), eura_pkg::WORD_W'($urandom),
                 eura_pkg::TEMP_W'($urandom));
   endtask

   // Lets every outstanding result come back, plus a little slack.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [eura_pkg::ANGLE_W-1:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      wrap_thr  = int'(value);
   endtask

   // The first frame after reset sets the bias, so its rate is zero.
   task automatic test_first_frame();
      send_frame(13'd8191, 16'hFFFF, 16'h0000, 8'hFF);
      send_frame(13'd8191, 16'h0000, 16'hFFFF, 8'h00);
   endtask

   // Differences just inside and just beyond the reset threshold.
   task automatic test_wrap_boundaries();
      send_angle(13'd0);
      send_angle(13'd8191);
      send_angle(13'd2191);
      send_angle(13'd8191);
      send_angle(13'd2190);
      send_angle(13'd8191);
   endtask

   // A zero threshold wraps on any movement; the largest never wraps.
   task automatic test_threshold_extremes();
      write_threshold(13'd0);
      send_angle(13'd8191);
      send_angle(13'd8190);
      send_angle(13'd8191);
      send_angle(13'd8191);
      write_threshold(13'd8191);
      send_angle(13'd0);
      send_angle(13'd8191);
      send_angle(13'd0);
      send_angle(13'd0);
   endtask

   // Mostly smooth rotation with random steps, some steps right at the
   // threshold, and some frames with an angle out of nowhere.
   task automatic test_random_rotation(input idle_mode_type mode, input int thr,
         input int count);
      int                           pick;
      int                           span;
      int                           step;
      logic [eura_pkg::ANGLE_W-1:0] angle;
      set_idling(mode);
      write_threshold(eura_pkg::ANGLE_W'(thr));
      for (int n = 0; n < count; n++) begin
         pick = int'($urandom_range(99));
         if (pick < 70) begin
            if ($urandom_range(3) == 0) span = 8191;
            else span = $urandom_range(1) ? 2048 : 64;
            step  = int'($urandom_range(2 * span)) - span;
            angle = eura_pkg::ANGLE_W'(enc_prev + step);
         end else if (pick < 88) begin
            step = wrap_thr + int'($urandom_range(1));
            if ($urandom_range(1)) step = -step;
            angle = eura_pkg::ANGLE_W'(enc_prev + step);
         end else begin
            angle = eura_pkg::ANGLE_W'($urandom);
         end
         send_angle(angle);
      end
   endtask

   // With a zero threshold each falling step counts a turn up and each
   // rising step a turn down; a run of each moves the count steadily.
   task automatic test_turn_runs();
      set_idling(IDLE_NONE);
      write_threshold(13'd0);
      repeat (20)
         send_angle(eura_pkg::ANGLE_W'(enc_prev - int'($urandom_range(1, 3))));
      repeat (20)
         send_angle(eura_pkg::ANGLE_W'(enc_prev + int'($urandom_range(1, 3))));
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_first_frame();
      test_wrap_boundaries();
      test_threshold_extremes();
      test_random_rotation(IDLE_NONE, eura_pkg::THRESHOLD_RESET, 250);
      test_random_rotation(IDLE_SENDER, 4096, 300);
      test_random_rotation(IDLE_RECEIVER, 0, 300);
      test_random_rotation(IDLE_BOTH, 8191, 300);
      test_turn_runs();
      test_random_rotation(IDLE_NONE, int'($urandom_range(8191)), 300);
      test_random_rotation(IDLE_BOTH, int'($urandom_range(8191)), 400);

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
